[rtl/ordered_list_engine_core_assert.svh]
// Assertion macros used by the port-level checker (ole_chk) of the ordered list engine.
// Both macros sample on the rising edge of clock and stay quiet while reset is high.
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define OLE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// Types and codes shared by the ordered list engine: request and response
// payloads, command and status codes, and the control/status link between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

   localparam logic [3:0] CMD_INS_HEAD = 4'd0;
   localparam logic [3:0] CMD_INS_TAIL = 4'd1;
   localparam logic [3:0] CMD_INS_POS  = 4'd2;
   localparam logic [3:0] CMD_DEL_HEAD = 4'd3;
   localparam logic [3:0] CMD_DEL_TAIL = 4'd4;
   localparam logic [3:0] CMD_DEL_POS  = 4'd5;
   localparam logic [3:0] CMD_LIST     = 4'd6;
   localparam logic [3:0] CMD_REVERSE  = 4'd7;
   localparam logic [3:0] CMD_SORT     = 4'd8;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] value;
      logic [5:0]         position;
   } ole_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic               last;
      logic [6:0]         length;
   } ole_rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SETUP_INS,
      OP_SETUP_DEL,
      OP_SETUP_LIST,
      OP_INS_READ,
      OP_INS_SHIFT,
      OP_INS_PUT,
      OP_DEL_READ,
      OP_DEL_SHIFT,
      OP_DEL_DROP,
      OP_REV_READ_LO,
      OP_REV_READ_HI,
      OP_REV_WRITE_LO,
      OP_REV_WRITE_HI,
      OP_LIST_START,
      OP_SORT_READ_I,
      OP_SORT_LOAD,
      OP_SORT_READ_J,
      OP_SORT_CMP,
      OP_SORT_PUT_I,
      OP_LIST_READ,
      OP_LIST_EMIT,
      OP_STATUS_EMIT
   } ole_op_type;

   typedef struct packed {
      ole_op_type op;
      logic [1:0] status;
   } ole_cmd_type;

   typedef struct packed {
      logic [3:0] command;
      logic       full;
      logic       empty;
      logic       pos_out;
      logic       ins_more;
      logic       del_more;
      logic       rev_more;
      logic       i_more;
      logic       j_more;
      logic       at_last;
   } ole_stat_type;

endpackage

`default_nettype wire

[rtl/ole_ram.sv]
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 16,
   parameter int ADDR_WIDTH = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ole_ctrl.sv]
// ----------------------------------------------------------------------------
// ole_ctrl
// Sequencer of the ordered list engine. Walks each command through its
// shift, reverse, sort or list loop and drives one datapath operation per
// cycle while not waiting on a stalled output. Owns the request ready and the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ctrl
   import ole_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ole_stat_type stat,
   output ole_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_INS,
      S_INS_SHIFT,
      S_DEL,
      S_DEL_SHIFT,
      S_REV,
      S_REV_HI,
      S_REV_WLO,
      S_REV_WHI,
      S_SORT_I,
      S_SORT_LOAD,
      S_SORT_J,
      S_SORT_CMP,
      S_LIST_RD,
      S_LIST_OUT,
      S_RESULT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] st_ff, st_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       emit;
   ole_op_type op;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      op       = OP_NONE;
      emit     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.command) inside
               CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                  if (stat.full) begin
                     st_in    = ST_FULL;
                     state_in = S_RESULT;
                  end else if (stat.command == CMD_INS_POS && stat.empty) begin
                     st_in    = ST_EMPTY;
                     state_in = S_RESULT;
                  end else if (stat.command == CMD_INS_POS && stat.pos_out) begin
                     st_in    = ST_BADPOS;
                     state_in = S_RESULT;
                  end else begin
                     op       = OP_SETUP_INS;
                     state_in = S_INS;
                  end
               end
               CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
                  if (stat.empty) begin
                     st_in    = ST_EMPTY;
                     state_in = S_RESULT;
                  end else if (stat.command == CMD_DEL_POS && stat.pos_out) begin
                     st_in    = ST_BADPOS;
                     state_in = S_RESULT;
                  end else begin
                     op       = OP_SETUP_DEL;
                     state_in = S_DEL;
                  end
               end
               CMD_LIST, CMD_REVERSE, CMD_SORT: begin
                  if (stat.empty) begin
                     st_in    = ST_EMPTY;
                     state_in = S_RESULT;
                  end else begin
                     op = OP_SETUP_LIST;
                     if (stat.command == CMD_REVERSE) begin
                        state_in = S_REV;
                     end else if (stat.command == CMD_SORT) begin
                        state_in = S_SORT_I;
                     end else begin
                        state_in = S_LIST_RD;
                     end
                  end
               end
               // drop unknown commands silently
               default: state_in = S_IDLE;
            endcase
         end
         S_INS: begin
            if (stat.ins_more) begin
               op       = OP_INS_READ;
               state_in = S_INS_SHIFT;
            end else begin
               op       = OP_INS_PUT;
               st_in    = ST_OK;
               state_in = S_RESULT;
            end
         end
         S_INS_SHIFT: begin
            op       = OP_INS_SHIFT;
            state_in = S_INS;
         end
         S_DEL: begin
            if (stat.del_more) begin
               op       = OP_DEL_READ;
               state_in = S_DEL_SHIFT;
            end else begin
               op       = OP_DEL_DROP;
               st_in    = ST_OK;
               state_in = S_RESULT;
            end
         end
         S_DEL_SHIFT: begin
            op       = OP_DEL_SHIFT;
            state_in = S_DEL;
         end
         S_REV: begin
            if (stat.rev_more) begin
               op       = OP_REV_READ_LO;
               state_in = S_REV_HI;
            end else begin
               op       = OP_LIST_START;
               state_in = S_LIST_RD;
            end
         end
         S_REV_HI: begin
            op       = OP_REV_READ_HI;
            state_in = S_REV_WLO;
         end
         S_REV_WLO: begin
            op       = OP_REV_WRITE_LO;
            state_in = S_REV_WHI;
         end
         S_REV_WHI: begin
            op       = OP_REV_WRITE_HI;
            state_in = S_REV;
         end
         S_SORT_I: begin
            if (stat.i_more) begin
               op       = OP_SORT_READ_I;
               state_in = S_SORT_LOAD;
            end else begin
               op       = OP_LIST_START;
               state_in = S_LIST_RD;
            end
         end
         S_SORT_LOAD: begin
            op       = OP_SORT_LOAD;
            state_in = S_SORT_J;
         end
         S_SORT_J: begin
            if (stat.j_more) begin
               op       = OP_SORT_READ_J;
               state_in = S_SORT_CMP;
            end else begin
               op       = OP_SORT_PUT_I;
               state_in = S_SORT_I;
            end
         end
         S_SORT_CMP: begin
            op       = OP_SORT_CMP;
            state_in = S_SORT_J;
         end
         S_LIST_RD: begin
            op       = OP_LIST_READ;
            state_in = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            // hold the read data until the output register is free
            if (slot_free) begin
               op       = OP_LIST_EMIT;
               emit     = 1'b1;
               state_in = stat.at_last ? S_IDLE : S_LIST_RD;
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               op       = OP_STATUS_EMIT;
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         st_ff        <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.op     = op;
   assign cmd.status = st_ff;

endmodule

`default_nettype wire

[rtl/ole_dp.sv]
// ----------------------------------------------------------------------------
// ole_dp
// Datapath of the ordered list engine: element store, element count, the
// two walking indexes, the held compare operand and the response register.
// Executes one operation per cycle as the controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_dp
   import ole_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  ole_req_type  req_data,
   input  ole_cmd_type  cmd,
   output ole_stat_type stat,
   output ole_rsp_type  rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   logic [3:0]         command_ff, command_in;
   logic signed [31:0] value_ff, value_in;
   logic [5:0]         position_ff, position_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      jdx_ff, jdx_in;
   logic [CW-1:0]      base_ff, base_in;
   logic signed [31:0] a_ff, a_in;
   ole_rsp_type        rsp_ff, rsp_in;

   logic [CW-1:0]      idx_inc, idx_dec, jdx_inc, jdx_dec;
   logic [6:0]         pos_wide, pos_plus, count_wide;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic signed [31:0] wr_data, rd_data;

   assign idx_inc    = idx_ff + CW'(1);
   assign idx_dec    = idx_ff - CW'(1);
   assign jdx_inc    = jdx_ff + CW'(1);
   assign jdx_dec    = jdx_ff - CW'(1);
   assign pos_wide   = {1'b0, position_ff};
   assign pos_plus   = pos_wide + 7'd1;
   assign count_wide = 7'(count_ff);

   assign stat.command  = command_ff;
   assign stat.full     = (count_ff == CW'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.pos_out  = (pos_wide >= count_wide);
   assign stat.ins_more = (idx_ff > base_ff);
   assign stat.del_more = (idx_inc < count_ff);
   assign stat.rev_more = (jdx_ff > idx_ff);
   assign stat.i_more   = (idx_ff < count_ff);
   assign stat.j_more   = (jdx_ff < count_ff);
   assign stat.at_last  = (idx_inc == count_ff);

   always_comb begin
      command_in  = command_ff;
      value_in    = value_ff;
      position_in = position_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      jdx_in      = jdx_ff;
      base_in     = base_ff;
      a_in        = a_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = rd_data;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[AW-1:0];
      unique case (cmd.op)
         OP_CAPTURE: begin
            command_in  = req_data.command;
            value_in    = req_data.value;
            position_in = req_data.position;
         end
         OP_SETUP_INS: begin
            idx_in = count_ff;
            case (command_ff)
               CMD_INS_HEAD: base_in = '0;
               CMD_INS_TAIL: base_in = count_ff;
               default:      base_in = pos_plus[CW-1:0];
            endcase
         end
         OP_SETUP_DEL: begin
            case (command_ff)
               CMD_DEL_HEAD: idx_in = '0;
               CMD_DEL_TAIL: idx_in = count_ff - CW'(1);
               default:      idx_in = pos_wide[CW-1:0];
            endcase
         end
         OP_SETUP_LIST: begin
            idx_in = '0;
            jdx_in = count_ff - CW'(1);
         end
         OP_INS_READ: begin
            rd_en   = 1'b1;
            rd_addr = idx_dec[AW-1:0];
         end
         OP_INS_SHIFT: begin
            wr_en  = 1'b1;
            idx_in = idx_dec;
         end
         OP_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = base_ff[AW-1:0];
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
         end
         OP_DEL_READ: begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
         end
         OP_DEL_SHIFT: begin
            wr_en  = 1'b1;
            idx_in = idx_inc;
         end
         OP_DEL_DROP: begin
            count_in = count_ff - CW'(1);
         end
         OP_REV_READ_LO: begin
            rd_en = 1'b1;
         end
         OP_REV_READ_HI: begin
            rd_en   = 1'b1;
            rd_addr = jdx_ff[AW-1:0];
            a_in    = rd_data;
         end
         OP_REV_WRITE_LO: begin
            wr_en = 1'b1;
         end
         OP_REV_WRITE_HI: begin
            wr_en   = 1'b1;
            wr_addr = jdx_ff[AW-1:0];
            wr_data = a_ff;
            idx_in  = idx_inc;
            jdx_in  = jdx_dec;
         end
         OP_LIST_START: begin
            idx_in = '0;
         end
         OP_SORT_READ_I: begin
            rd_en  = 1'b1;
            jdx_in = idx_inc;
         end
         OP_SORT_LOAD: begin
            a_in = rd_data;
         end
         OP_SORT_READ_J: begin
            rd_en   = 1'b1;
            rd_addr = jdx_ff[AW-1:0];
         end
         OP_SORT_CMP: begin
            // keep the running minimum in a_ff; store slot i is written once at the end
            if (a_ff > rd_data) begin
               wr_en   = 1'b1;
               wr_addr = jdx_ff[AW-1:0];
               wr_data = a_ff;
               a_in    = rd_data;
            end
            jdx_in = jdx_inc;
         end
         OP_SORT_PUT_I: begin
            wr_en   = 1'b1;
            wr_data = a_ff;
            idx_in  = idx_inc;
         end
         OP_LIST_READ: begin
            rd_en = 1'b1;
         end
         OP_LIST_EMIT: begin
            rsp_in.status  = ST_OK;
            rsp_in.element = rd_data;
            rsp_in.last    = stat.at_last;
            rsp_in.length  = count_wide;
            idx_in         = idx_inc;
         end
         OP_STATUS_EMIT: begin
            rsp_in.status  = cmd.status;
            rsp_in.element = '0;
            rsp_in.last    = 1'b1;
            rsp_in.length  = count_wide;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff  <= command_in;
      value_ff    <= value_in;
      position_ff <= position_in;
      idx_ff      <= idx_in;
      jdx_ff      <= jdx_in;
      base_ff     <= base_in;
      a_ff        <= a_in;
      rsp_ff      <= rsp_in;
   end

   ole_ram #(
      .WIDTH      (32),
      .DEPTH      (CAPACITY),
      .ADDR_WIDTH (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/ordered_list_engine_core.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Bounded ordered list of signed 32-bit values with insert, delete, list,
// reverse and sort commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer (command, value, position).
//   rsp_* returns the results: one status transfer for insert and delete, one
//   transfer per element for list, reverse and sort (last marks the final one),
//   or a single empty status when a listing command finds the list empty.
//   Commands 9 to 15 are dropped and return nothing.
//   Commands run one at a time; req_ready rises again once the last result of
//   the current command sits in the output register, so the next command is
//   taken while that result still waits to be taken.
//   Each command walks the element store, which has a single read port and
//   takes one read or one write per cycle:
//     insert and delete move each element from the slot on, by a read and a write
//     list reads and emits each element in turn; reverse first swaps the pairs
//     sort first runs an exchange walk (a read and a compare per later element)
//   Reset empties the list and drops any pending result; the store is not
//   cleared since entries past the count are never read.
//   A stall on rsp_ready holds the output register and freezes the engine
//   at its next emit until the transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_core
   import ole_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ole_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ole_rsp_type rsp_data
);

   ole_cmd_type  cmd;
   ole_stat_type stat;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ole_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/ole_chk.sv]
// ----------------------------------------------------------------------------
// ole_chk
// Port-level checker for the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_engine_core_assert.svh"

module ole_chk
   import ole_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input ole_rsp_type rsp_data
);

   `OLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
   `OLE_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while a command is in flight")
   `OLE_ASSERT_IMPLY(a_length_bound, rsp_valid, rsp_data.length <= 7'(CAPACITY), "length beyond capacity")
   `OLE_ASSERT_IMPLY(a_status_alone, rsp_valid && rsp_data.status != ST_OK, rsp_data.element == '0 && rsp_data.last, "error status not a lone zero result")

endmodule

bind ordered_list_engine_core ole_chk #(
   .CAPACITY (CAPACITY)
) u_ole_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
